// ----- design/ghash_accumulator_defines.svh -----
// ----------------------------------------------------------------------------
// ghash accumulator assertion macros
// concurrent checks on clk with asynchronous active-low reset rst_n;
// empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GHASH_ACCUMULATOR_DEFINES_SVH
`define GHASH_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define GHA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ghash accumulator check failed");
// antecedent implies consequent in the next cycle
`define GHA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ghash accumulator check failed");
`else
`define GHA_ASSERT_IMP(name, ante, cons)
`define GHA_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ----- design/gha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg
// shared types and constants of the ghash accumulator
// ----------------------------------------------------------------------------
package gha_pkg;

    // field and block widths
    localparam int HALF_W     = 64;
    localparam int BLOCK_W    = 2 * HALF_W;
    localparam int CNT_W      = $clog2(BLOCK_W);
    localparam int CFG_INDEX_W = 2;

    // last step of the bit-serial multiply
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_W - 1);

    // reflected reduction constant placed at the top byte
    localparam logic [BLOCK_W-1:0] REDUCE_POLY = {8'hE1, {(BLOCK_W - 8){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = CFG_INDEX_W'(1);

    // input item
    typedef struct packed {
        logic [HALF_W-1:0] block_high;
        logic [HALF_W-1:0] block_low;
        logic              first;
        logic              last;
    } blk_item_t;

    // result item
    typedef struct packed {
        logic [HALF_W-1:0] hash_high;
        logic [HALF_W-1:0] hash_low;
    } hash_item_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } gha_cmd_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_EMIT
    } gha_state_t;

endpackage

// ----- design/gha_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_datapath
// key registers, accumulator and bit-serial GF(2^128) multiplier, one operand
// bit per step, plus the result register
// ----------------------------------------------------------------------------
module gha_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [gha_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gha_pkg::HALF_W-1:0]         cfg_data,
    input  gha_pkg::blk_item_t                 blk,
    input  gha_pkg::gha_cmd_t                  cmd,
    output gha_pkg::hash_item_t                hash
);
    import gha_pkg::*;

    logic [HALF_W-1:0]  key_high_reg;
    logic [HALF_W-1:0]  key_low_reg;
    logic [BLOCK_W-1:0] acc_reg;
    logic [BLOCK_W-1:0] acc_next;
    logic [BLOCK_W-1:0] x_reg;
    logic [BLOCK_W-1:0] x_next;
    logic [BLOCK_W-1:0] v_reg;
    logic [BLOCK_W-1:0] v_next;
    logic [BLOCK_W-1:0] hash_reg;
    logic [BLOCK_W-1:0] seed;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_KEY_HIGH)
            begin
                key_high_reg <= cfg_data;
            end
            if (cfg_index == REG_KEY_LOW)
            begin
                key_low_reg <= cfg_data;
            end
        end
    end

    // operand: block xor running hash, cleared on first
    assign seed = blk.first ? '0 : acc_reg;

    // load the operands, or multiply step: accumulate, shift operand, shift and reduce key power
    always_comb
    begin
        acc_next = acc_reg;
        x_next   = x_reg;
        v_next   = v_reg;
        if (cmd.load)
        begin
            acc_next = '0;
            x_next   = seed ^ {blk.block_high, blk.block_low};
            v_next   = {key_high_reg, key_low_reg};
        end
        else if (cmd.step)
        begin
            acc_next = acc_reg ^ (v_reg & {BLOCK_W{x_reg[BLOCK_W-1]}});
            x_next   = {x_reg[BLOCK_W-2:0], 1'b0};
            v_next   = {1'b0, v_reg[BLOCK_W-1:1]} ^ (REDUCE_POLY & {BLOCK_W{v_reg[0]}});
        end
    end

    // accumulator holds the running hash between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // multiplier operands
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        v_reg <= v_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hash_reg <= acc_reg;
        end
    end

    assign hash.hash_high = hash_reg[BLOCK_W-1:HALF_W];
    assign hash.hash_low  = hash_reg[HALF_W-1:0];

endmodule

// ----- design/gha_ctrl.sv -----
`timescale 1ns / 1ps
`include "ghash_accumulator_defines.svh"
// ----------------------------------------------------------------------------
// gha_ctrl
// sequencer for the ghash accumulator: takes an item, runs the 128 multiply
// steps, and hands the hash to the output register on last
// ----------------------------------------------------------------------------
module gha_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               blk_valid,
    output logic               blk_stall,
    input  logic               blk_last,
    output logic               hash_valid,
    input  logic               hash_stall,
    output gha_pkg::gha_cmd_t  cmd
);
    import gha_pkg::*;

    gha_state_t        state_reg;
    gha_state_t        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              last_reg;
    logic              last_next;
    logic              hash_valid_reg;
    logic              hash_valid_next;
    logic              blk_accept;
    logic              slot_free;

    assign blk_stall  = (state_reg != ST_IDLE);
    assign blk_accept = blk_valid && !blk_stall;
    assign slot_free  = !hash_valid_reg || !hash_stall;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            last_reg       <= 1'b0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            last_reg       <= last_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (blk_accept)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    last_next  = blk_last;
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output item valid
    always_comb
    begin
        if (cmd.emit)
        begin
            hash_valid_next = 1'b1;
        end
        else
        begin
            hash_valid_next = hash_valid_reg && hash_stall;
        end
    end

    assign hash_valid = hash_valid_reg;

    // checks
    `GHA_ASSERT_NXT(a_accept_starts, blk_accept, (state_reg == ST_MULT) && (cnt_reg == '0))
    `GHA_ASSERT_IMP(a_emit_slot_free, cmd.emit, slot_free)
    `GHA_ASSERT_NXT(a_no_last_to_idle, (state_reg == ST_MULT) && (cnt_reg == CNT_LAST) && !last_reg, state_reg == ST_IDLE)
    `GHA_ASSERT_NXT(a_step_count, (state_reg == ST_MULT) && (cnt_reg != CNT_LAST), (state_reg == ST_MULT) && (cnt_reg == $past(cnt_reg) + CNT_W'(1)))

endmodule

// ----- design/ghash_accumulator.sv -----
// an item with last set runs its multiply steps, then the emit state loads the
// result register and sets hash_valid once the output slot is free
// no new item is taken until the multiply steps, and the emit when last is set,
// are done; the bit-serial GF(2^128) multiplier handles one operand bit per step
// a finished hash waits in the output register while the next item runs
// reset clears the keys, the running hash and all control state
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_accumulator
// GHASH universal hash: each 128-bit item is xored into the running hash,
// which is then multiplied by key H in GF(2^128)
// ----------------------------------------------------------------------------
module ghash_accumulator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gha_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gha_pkg::HALF_W-1:0]       cfg_data,
    input  logic                             blk_valid,
    output logic                             blk_stall,
    input  gha_pkg::blk_item_t               blk,
    output logic                             hash_valid,
    input  logic                             hash_stall,
    output gha_pkg::hash_item_t              hash
);
    import gha_pkg::*;

    gha_cmd_t cmd;

    // sequencer
    gha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .blk_valid  (blk_valid),
        .blk_stall  (blk_stall),
        .blk_last   (blk.last),
        .hash_valid (hash_valid),
        .hash_stall (hash_stall),
        .cmd        (cmd)
    );

    // multiplier and registers
    gha_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .blk       (blk),
        .cmd       (cmd),
        .hash      (hash)
    );

endmodule
